>>> rtl/core/wcb_pkg.sv
// Shared types and constants of the window crop and bin reduce block.
`timescale 1ns / 1ps
package wcb_pkg;

  // Fixed widths of the datapath.
  localparam int unsigned PW          = 17;  // position arithmetic, signed
  localparam int unsigned SUM_W       = 25;  // block sums
  localparam int unsigned DVD_W       = 26;  // divider dividend and quotient
  localparam int unsigned DVS_W       = 10;  // divider divisor (bin squared)
  localparam int unsigned CNT_W       = 5;   // divider step counter
  localparam int unsigned SHORT_STEPS = 16;  // steps for position divisions
  localparam int unsigned ROW_W       = 12;
  localparam logic [ROW_W-1:0] LAST_ROW = 12'd4095;

  // Pixel modes.
  localparam logic [1:0] MODE_BYTE   = 2'd0;
  localparam logic [1:0] MODE_SHORT  = 2'd1;
  localparam logic [1:0] MODE_USHORT = 2'd2;
  localparam logic [1:0] MODE_RGB    = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [2:0] REG_BIN_FACTOR = 3'd1;
  localparam logic [2:0] REG_KEEP_BYTE  = 3'd2;
  localparam logic [2:0] REG_LINE_WIDTH = 3'd3;
  localparam logic [2:0] REG_WIN_X_FIRST = 3'd4;
  localparam logic [2:0] REG_WIN_X_LAST  = 3'd5;
  localparam logic [2:0] REG_WIN_Y_FIRST = 3'd6;
  localparam logic [2:0] REG_WIN_Y_LAST  = 3'd7;

  // Result status codes.
  localparam logic STATUS_PIXEL = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  typedef struct packed {
    logic [1:0]  pixel_mode;
    logic [4:0]  bin_factor;
    logic        keep_byte;
    logic [12:0] line_width;
    logic [11:0] win_x_first;
    logic [11:0] win_x_last;
    logic [11:0] win_y_first;
    logic [11:0] win_y_last;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV,
    OP_ACCUM,
    OP_MEM_RD,
    OP_MEM_WR,
    OP_EMIT_PIX,
    OP_EMIT_ERR,
    OP_ADVANCE
  } dp_op_e;

  typedef enum logic [2:0] {
    DS_NX,
    DS_NY,
    DS_QX,
    DS_QY,
    DS_AVG
  } div_sel_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NX,
    ST_NX_W,
    ST_NY,
    ST_NY_W,
    ST_CHECK,
    ST_QX,
    ST_QX_W,
    ST_QY,
    ST_QY_W,
    ST_INSIDE,
    ST_RD,
    ST_WR,
    ST_AVG,
    ST_AVG_W,
    ST_EMIT,
    ST_ERR,
    ST_ADV
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e     op;
    div_sel_e   dsel;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic err_cond;
    logic err_reported;
    logic cand;
    logic in_win;
    logic col_end;
    logic row_end;
    logic avg_path;
    logic rgb;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/wcb_intf.sv
// Channel interfaces of the window crop and bin reduce block.
`timescale 1ns / 1ps
interface wcb_pix_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [16:0] sample_main;
  logic [7:0]         sample_green;
  logic [7:0]         sample_blue;
  modport source (output valid, frame_start, sample_main, sample_green, sample_blue,
                  input ready);
  modport sink (input valid, frame_start, sample_main, sample_green, sample_blue,
                output ready);
endinterface

interface wcb_res_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic signed [16:0] result_main;
  logic [7:0]         result_green;
  logic [7:0]         result_blue;
  logic               row_end;
  logic               frame_end;
  modport source (output valid, status, result_main, result_green, result_blue, row_end,
                  frame_end, input ready);
  modport sink (input valid, status, result_main, result_green, result_blue, row_end,
                frame_end, output ready);
endinterface

interface wcb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/wcb_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wcb_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      short_i,
  input  logic [wcb_pkg::DVD_W-1:0] dividend_i,
  input  logic [wcb_pkg::DVS_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [wcb_pkg::DVD_W-1:0] quotient_o,
  output logic [wcb_pkg::DVS_W-1:0] remainder_o
);

  logic [wcb_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [wcb_pkg::DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [wcb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [wcb_pkg::DVS_W:0]   trial;
  logic [wcb_pkg::DVS_W:0]   diff;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    trial  = {rem_q, quo_q[wcb_pkg::DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // Short divisions skip the upper dividend bits, which are zero.
      quo_d  = short_i ? (dividend_i << (wcb_pkg::DVD_W - wcb_pkg::SHORT_STEPS))
                       : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = short_i ? wcb_pkg::CNT_W'(wcb_pkg::SHORT_STEPS)
                       : wcb_pkg::CNT_W'(wcb_pkg::DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[wcb_pkg::DVD_W-2:0], ~diff[wcb_pkg::DVS_W]};
      rem_d = diff[wcb_pkg::DVS_W] ? trial[wcb_pkg::DVS_W-1:0] : diff[wcb_pkg::DVS_W-1:0];
      cnt_d = cnt_q - wcb_pkg::CNT_W'(1);
      if (cnt_q == wcb_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/core/wcb_datapath.sv
// Datapath: position counters, window geometry, block sums, column store and result word.
`timescale 1ns / 1ps
module wcb_datapath #(
  parameter int unsigned MAX_LINE = 4096,
  parameter int unsigned MAX_BIN  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wcb_pkg::cfg_t       cfg_i,
  input  wcb_pkg::cmd_t       cmd_i,
  output wcb_pkg::sts_t       sts_o,
  input  logic                frame_start_i,
  input  logic signed [16:0]  sample_main_i,
  input  logic [7:0]          sample_green_i,
  input  logic [7:0]          sample_blue_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_status_o,
  output logic signed [16:0]  out_main_o,
  output logic [7:0]          out_green_o,
  output logic [7:0]          out_blue_o,
  output logic                out_row_end_o,
  output logic                out_frame_end_o
);

  localparam int unsigned CW        = $clog2(MAX_LINE);
  localparam int unsigned MEM_DEPTH = 3 * (MAX_LINE / 2);
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned PW        = wcb_pkg::PW;
  localparam int unsigned SW        = wcb_pkg::SUM_W;
  localparam int unsigned DW        = wcb_pkg::DVD_W;

  // Derived configuration.
  logic [4:0]          nb;
  logic [9:0]          nsq;
  logic [PW-1:0]       lw;
  logic signed [PW-1:0] nxin, nyin;
  logic                nx_pos, ny_pos, rgb, avg_path;

  always_comb begin
    if (cfg_i.bin_factor == 5'd0) begin
      nb = 5'd1;
    end else if (32'(cfg_i.bin_factor) > MAX_BIN) begin
      nb = 5'(MAX_BIN);
    end else begin
      nb = cfg_i.bin_factor;
    end
    if (cfg_i.line_width == 13'd0) begin
      lw = PW'(1);
    end else if (32'(cfg_i.line_width) > MAX_LINE) begin
      lw = PW'(MAX_LINE);
    end else begin
      lw = PW'(cfg_i.line_width);
    end
  end

  assign nsq      = {5'd0, nb} * {5'd0, nb};
  assign nxin     = PW'(cfg_i.win_x_last) + PW'(1) - PW'(cfg_i.win_x_first);
  assign nyin     = PW'(cfg_i.win_y_last) + PW'(1) - PW'(cfg_i.win_y_first);
  assign nx_pos   = !nxin[PW-1] && (nxin != '0);
  assign ny_pos   = !nyin[PW-1] && (nyin != '0);
  assign rgb      = cfg_i.pixel_mode == wcb_pkg::MODE_RGB;
  assign avg_path = (cfg_i.pixel_mode == wcb_pkg::MODE_SHORT) ||
                    (cfg_i.pixel_mode == wcb_pkg::MODE_USHORT) || cfg_i.keep_byte;

  // State registers.
  logic [CW-1:0]            col_q;
  logic [wcb_pkg::ROW_W-1:0] row_q;
  logic                     frame_done_q, err_rep_q, out_valid_q;
  logic [SW-1:0]            run_q [3];
  logic [SW-1:0]            tot_q [3];
  logic [16:0]              avg_q [3];
  logic signed [16:0]       v0_q;
  logic [7:0]               v1_q, v2_q;
  logic [PW-1:0]            nxout_q, nyout_q, xs_q, ys_q, ox_q, oy_q;
  logic [4:0]               cx_q, ry_q;
  logic [1:0]               div_ch_q;
  logic                     neg_q;
  wcb_pkg::div_sel_e        dsel_q;
  logic [SW-1:0]            rd_q;

  // Positions.
  logic [PW-1:0] col_s, row_s;
  assign col_s = PW'(col_q);
  assign row_s = PW'(row_q);

  // Divider operands.
  logic signed [DW-1:0] avg_dvd;
  logic [DW-1:0]        dvd, quo, neg_quo;
  logic [wcb_pkg::DVS_W-1:0] dvs, rem;
  logic                 div_start, div_busy, div_done;

  assign avg_dvd = DW'($signed(tot_q[cmd_i.ch])) + DW'(nsq >> 1);

  always_comb begin
    unique case (cmd_i.dsel)
      wcb_pkg::DS_NX:  dvd = nx_pos ? DW'(nxin) : '0;
      wcb_pkg::DS_NY:  dvd = ny_pos ? DW'(nyin) : '0;
      wcb_pkg::DS_QX:  dvd = DW'(col_s - xs_q);
      wcb_pkg::DS_QY:  dvd = DW'(row_s - ys_q);
      wcb_pkg::DS_AVG: dvd = avg_dvd[DW-1] ? DW'(-avg_dvd) : DW'(avg_dvd);
      default:         dvd = '0;
    endcase
  end

  assign dvs       = (cmd_i.dsel == wcb_pkg::DS_AVG) ? nsq : wcb_pkg::DVS_W'(nb);
  assign div_start = cmd_i.op == wcb_pkg::OP_DIV;

  wcb_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .short_i     (cmd_i.dsel != wcb_pkg::DS_AVG),
    .dividend_i  (dvd),
    .divisor_i   (dvs),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  assign neg_quo = -quo;

  // Sample as used by the current pixel mode.
  logic signed [16:0] v0_d;
  always_comb begin
    unique case (cfg_i.pixel_mode)
      wcb_pkg::MODE_SHORT:  v0_d = {sample_main_i[15], sample_main_i[15:0]};
      wcb_pkg::MODE_USHORT: v0_d = {1'b0, sample_main_i[15:0]};
      default:              v0_d = {9'd0, sample_main_i[7:0]};
    endcase
  end

  logic [SW-1:0] vx [3];
  assign vx[0] = {{(SW-17){v0_q[16]}}, v0_q};
  assign vx[1] = {{(SW-8){1'b0}}, v1_q};
  assign vx[2] = {{(SW-8){1'b0}}, v2_q};

  // Column store access.
  logic [PW+1:0] addr_full;
  logic [AW-1:0] addr;
  logic [SW-1:0] prev, tot_new;
  logic          mem_we, mem_re;
  assign addr_full = {ox_q, 1'b0} + {2'b00, ox_q} + (PW+2)'(cmd_i.ch);
  assign addr      = addr_full[AW-1:0];
  assign prev      = ((nb > 5'd1) && (ry_q != 5'd0)) ? rd_q : '0;
  assign tot_new   = prev + run_q[cmd_i.ch];
  assign mem_re    = cmd_i.op == wcb_pkg::OP_MEM_RD;
  assign mem_we    = (cmd_i.op == wcb_pkg::OP_MEM_WR) && (nb > 5'd1);

  logic [SW-1:0] mem [MEM_DEPTH];
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= tot_new;
    end
    if (mem_re) begin
      rd_q <= mem[addr];
    end
  end

  // Saturated sum for the plain-sum modes.
  logic signed [SW+1:0] sum3;
  logic signed [16:0]   sat_sum;
  assign sum3 = (SW+2)'($signed(tot_q[0])) +
                (rgb ? (SW+2)'($signed(tot_q[1])) + (SW+2)'($signed(tot_q[2]))
                     : (SW+2)'(0));
  always_comb begin
    if (sum3 > (SW+2)'(32767)) begin
      sat_sum = 17'sd32767;
    end else if (sum3 < -(SW+2)'(32768)) begin
      sat_sum = -17'sd32768;
    end else begin
      sat_sum = sum3[16:0];
    end
  end

  logic last_col;
  assign last_col = (col_s + PW'(1)) >= lw;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      frame_done_q <= 1'b0;
      err_rep_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        run_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        wcb_pkg::OP_CAPTURE: begin
          if (frame_start_i) begin
            col_q        <= '0;
            row_q        <= '0;
            frame_done_q <= 1'b0;
            err_rep_q    <= 1'b0;
          end
        end
        wcb_pkg::OP_ACCUM: begin
          for (int i = 0; i < 3; i++) begin
            run_q[i] <= (cx_q == 5'd0) ? vx[i] : run_q[i] + vx[i];
          end
        end
        wcb_pkg::OP_EMIT_PIX: out_valid_q <= 1'b1;
        wcb_pkg::OP_EMIT_ERR: begin
          out_valid_q <= 1'b1;
          err_rep_q   <= 1'b1;
        end
        wcb_pkg::OP_ADVANCE: begin
          if (last_col) begin
            col_q <= '0;
            if (row_q >= wcb_pkg::LAST_ROW) begin
              frame_done_q <= 1'b1;
            end else begin
              row_q <= row_q + 1'b1;
            end
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      wcb_pkg::OP_CAPTURE: begin
        v0_q <= v0_d;
        v1_q <= rgb ? sample_green_i : 8'd0;
        v2_q <= rgb ? sample_blue_i : 8'd0;
      end
      wcb_pkg::OP_DIV: begin
        dsel_q   <= cmd_i.dsel;
        div_ch_q <= cmd_i.ch;
        neg_q    <= avg_dvd[DW-1];
      end
      wcb_pkg::OP_MEM_WR: tot_q[cmd_i.ch] <= tot_new;
      wcb_pkg::OP_EMIT_PIX: begin
        out_status_o    <= wcb_pkg::STATUS_PIXEL;
        out_main_o      <= avg_path ? avg_q[0] : sat_sum;
        out_green_o     <= (avg_path && rgb) ? avg_q[1][7:0] : 8'd0;
        out_blue_o      <= (avg_path && rgb) ? avg_q[2][7:0] : 8'd0;
        out_row_end_o   <= ox_q == nxout_q - PW'(1);
        out_frame_end_o <= (ox_q == nxout_q - PW'(1)) && (oy_q == nyout_q - PW'(1));
      end
      wcb_pkg::OP_EMIT_ERR: begin
        out_status_o    <= wcb_pkg::STATUS_ERROR;
        out_main_o      <= '0;
        out_green_o     <= '0;
        out_blue_o      <= '0;
        out_row_end_o   <= 1'b0;
        out_frame_end_o <= 1'b0;
      end
      default: ;
    endcase
    // Division results land by the operand kind that started them.
    if (div_done) begin
      unique case (dsel_q)
        wcb_pkg::DS_NX: begin
          nxout_q <= quo[PW-1:0];
          xs_q    <= PW'(cfg_i.win_x_first) + PW'(rem[wcb_pkg::DVS_W-1:1]);
        end
        wcb_pkg::DS_NY: begin
          nyout_q <= quo[PW-1:0];
          ys_q    <= PW'(cfg_i.win_y_first) + PW'(rem[wcb_pkg::DVS_W-1:1]);
        end
        wcb_pkg::DS_QX: begin
          ox_q <= quo[PW-1:0];
          cx_q <= rem[4:0];
        end
        wcb_pkg::DS_QY: begin
          oy_q <= quo[PW-1:0];
          ry_q <= rem[4:0];
        end
        wcb_pkg::DS_AVG: avg_q[div_ch_q] <= neg_q ? neg_quo[16:0] : quo[16:0];
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.div_busy     = div_busy;
    sts_o.div_done     = div_done;
    sts_o.err_cond     = nxin > $signed(lw);
    sts_o.err_reported = err_rep_q;
    sts_o.cand         = !frame_done_q && (nxout_q != '0) && (nyout_q != '0) &&
                         (col_s >= xs_q) && (row_s >= ys_q);
    sts_o.in_win       = (ox_q < nxout_q) && (oy_q < nyout_q);
    sts_o.col_end      = cx_q == nb - 5'd1;
    sts_o.row_end      = ry_q == nb - 5'd1;
    sts_o.avg_path     = avg_path;
    sts_o.rgb          = rgb;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/wcb_ctrl.sv
// Controller: sequences one pixel word through geometry, binning and result steps.
`timescale 1ns / 1ps
module wcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  wcb_pkg::sts_t sts_i,
  output wcb_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);

  wcb_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]           ch_q, ch_d;

  // State and channel registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wcb_pkg::ST_IDLE;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    cmd_o.op   = wcb_pkg::OP_NONE;
    cmd_o.dsel = wcb_pkg::DS_NX;
    cmd_o.ch   = ch_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      wcb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = wcb_pkg::OP_CAPTURE;
          state_d  = wcb_pkg::ST_NX;
        end
      end
      wcb_pkg::ST_NX: begin
        cmd_o.op = wcb_pkg::OP_DIV;
        state_d  = wcb_pkg::ST_NX_W;
      end
      wcb_pkg::ST_NX_W: if (sts_i.div_done) state_d = wcb_pkg::ST_NY;
      wcb_pkg::ST_NY: begin
        cmd_o.op   = wcb_pkg::OP_DIV;
        cmd_o.dsel = wcb_pkg::DS_NY;
        state_d    = wcb_pkg::ST_NY_W;
      end
      wcb_pkg::ST_NY_W: if (sts_i.div_done) state_d = wcb_pkg::ST_CHECK;
      wcb_pkg::ST_CHECK: begin
        if (sts_i.err_cond) begin
          state_d = sts_i.err_reported ? wcb_pkg::ST_ADV : wcb_pkg::ST_ERR;
        end else begin
          state_d = sts_i.cand ? wcb_pkg::ST_QX : wcb_pkg::ST_ADV;
        end
      end
      wcb_pkg::ST_QX: begin
        cmd_o.op   = wcb_pkg::OP_DIV;
        cmd_o.dsel = wcb_pkg::DS_QX;
        state_d    = wcb_pkg::ST_QX_W;
      end
      wcb_pkg::ST_QX_W: if (sts_i.div_done) state_d = wcb_pkg::ST_QY;
      wcb_pkg::ST_QY: begin
        cmd_o.op   = wcb_pkg::OP_DIV;
        cmd_o.dsel = wcb_pkg::DS_QY;
        state_d    = wcb_pkg::ST_QY_W;
      end
      wcb_pkg::ST_QY_W: if (sts_i.div_done) state_d = wcb_pkg::ST_INSIDE;
      wcb_pkg::ST_INSIDE: begin
        if (sts_i.in_win) begin
          cmd_o.op = wcb_pkg::OP_ACCUM;
          ch_d     = '0;
          state_d  = sts_i.col_end ? wcb_pkg::ST_RD : wcb_pkg::ST_ADV;
        end else begin
          state_d = wcb_pkg::ST_ADV;
        end
      end
      wcb_pkg::ST_RD: begin
        cmd_o.op = wcb_pkg::OP_MEM_RD;
        state_d  = wcb_pkg::ST_WR;
      end
      wcb_pkg::ST_WR: begin
        cmd_o.op = wcb_pkg::OP_MEM_WR;
        if (ch_q == 2'd2) begin
          ch_d = '0;
          if (!sts_i.row_end) begin
            state_d = wcb_pkg::ST_ADV;
          end else begin
            state_d = sts_i.avg_path ? wcb_pkg::ST_AVG : wcb_pkg::ST_EMIT;
          end
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = wcb_pkg::ST_RD;
        end
      end
      wcb_pkg::ST_AVG: begin
        cmd_o.op   = wcb_pkg::OP_DIV;
        cmd_o.dsel = wcb_pkg::DS_AVG;
        state_d    = wcb_pkg::ST_AVG_W;
      end
      wcb_pkg::ST_AVG_W: begin
        if (sts_i.div_done) begin
          if (ch_q == 2'd2 || !sts_i.rgb) begin
            state_d = wcb_pkg::ST_EMIT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = wcb_pkg::ST_AVG;
          end
        end
      end
      wcb_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = wcb_pkg::OP_EMIT_PIX;
          state_d  = wcb_pkg::ST_ADV;
        end
      end
      wcb_pkg::ST_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.op = wcb_pkg::OP_EMIT_ERR;
          state_d  = wcb_pkg::ST_ADV;
        end
      end
      wcb_pkg::ST_ADV: begin
        cmd_o.op = wcb_pkg::OP_ADVANCE;
        state_d  = wcb_pkg::ST_IDLE;
      end
      default: state_d = wcb_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/window_crop_and_bin_reduce.sv
// Top level of the window crop and bin reduce block.
//
//   channel  | direction | word
//   pix_i    | in        | frame_start, sample_main, sample_green, sample_blue
//   res_o    | out       | status, result_main, result_green, result_blue, row_end, frame_end
//   cfg_i    | in        | index, data (register write, always ready)
//
// One pixel word at a time passes through a shared bit-serial divider, which sets the rate:
// every pixel takes the two window size divisions, one past the window start also the two
// position divisions, and the pixel that completes a bin adds three column store reads and
// writes plus up to three full-width averages. Reset clears counters, flags and configuration;
// the column store holds no reset state. A result waits in the output register while the next
// word is taken and worked on; only a new result stalls for the output side.
`timescale 1ns / 1ps
module window_crop_and_bin_reduce #(
  parameter int unsigned MAX_LINE = 4096,
  parameter int unsigned MAX_BIN  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wcb_pix_if.sink    pix_i,
  wcb_res_if.source  res_o,
  wcb_cfg_if.sink    cfg_i
);

  wcb_pkg::cfg_t cfg_q;
  wcb_pkg::cmd_t cmd;
  wcb_pkg::sts_t sts;
  logic          in_ready;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode  <= wcb_pkg::MODE_BYTE;
      cfg_q.bin_factor  <= 5'd1;
      cfg_q.keep_byte   <= 1'b1;
      cfg_q.line_width  <= 13'd4096;
      cfg_q.win_x_first <= 12'd0;
      cfg_q.win_x_last  <= 12'd4095;
      cfg_q.win_y_first <= 12'd0;
      cfg_q.win_y_last  <= 12'd4095;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        wcb_pkg::REG_PIXEL_MODE:  cfg_q.pixel_mode  <= cfg_i.data[1:0];
        wcb_pkg::REG_BIN_FACTOR:  cfg_q.bin_factor  <= cfg_i.data[4:0];
        wcb_pkg::REG_KEEP_BYTE:   cfg_q.keep_byte   <= cfg_i.data[0];
        wcb_pkg::REG_LINE_WIDTH:  cfg_q.line_width  <= cfg_i.data;
        wcb_pkg::REG_WIN_X_FIRST: cfg_q.win_x_first <= cfg_i.data[11:0];
        wcb_pkg::REG_WIN_X_LAST:  cfg_q.win_x_last  <= cfg_i.data[11:0];
        wcb_pkg::REG_WIN_Y_FIRST: cfg_q.win_y_first <= cfg_i.data[11:0];
        wcb_pkg::REG_WIN_Y_LAST:  cfg_q.win_y_last  <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  // Controller.
  wcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  assign pix_i.ready = in_ready;

  // Datapath.
  wcb_datapath #(
    .MAX_LINE (MAX_LINE),
    .MAX_BIN  (MAX_BIN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .frame_start_i   (pix_i.frame_start),
    .sample_main_i   (pix_i.sample_main),
    .sample_green_i  (pix_i.sample_green),
    .sample_blue_i   (pix_i.sample_blue),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .out_status_o    (res_o.status),
    .out_main_o      (res_o.result_main),
    .out_green_o     (res_o.result_green),
    .out_blue_o      (res_o.result_blue),
    .out_row_end_o   (res_o.row_end),
    .out_frame_end_o (res_o.frame_end)
  );

`ifndef ASSERT_OFF
  // A result is loaded only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == wcb_pkg::OP_EMIT_PIX || cmd.op == wcb_pkg::OP_EMIT_ERR) |-> sts.out_free)
    else $error("result loaded over an unread result");

  // The divider is never restarted while it is working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == wcb_pkg::OP_DIV) |-> !sts.div_busy)
    else $error("divider started while busy");

  // A taken pixel word keeps the input closed on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_i.valid && pix_i.ready) |=> !pix_i.ready)
    else $error("input reopened right after a word was taken");
`endif

endmodule

>>> verif/tb_window_crop_and_bin_reduce.sv
// Self-checking testbench of the window crop and bin reduce block: directed and random frames.
`timescale 1ns / 1ps
module tb_window_crop_and_bin_reduce;

  localparam int STORE_DEPTH = 6144;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic        status;
    logic [16:0] main;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        row_end;
    logic        frame_end;
  } bin_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wcb_pix_if pix ();
  wcb_res_if res ();
  wcb_cfg_if cfg ();

  window_crop_and_bin_reduce dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the configuration and of the binning state.
  wcb_pkg::cfg_t shadow_cfg;
  int        col_sums [STORE_DEPTH];
  int        run_sums [3];
  int        cur_col;
  int        cur_row;
  bit        err_sent;
  bit        rows_done;
  bin_word_t pending_bins[$];

  int mismatches = 0;
  int sent_pixels = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int idle_count = 0;

  function automatic int wrap25(int x);
    logic [24:0] t;
    t = x[24:0];
    return int'($signed(t));
  endfunction

  function automatic int sat16(int x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic int bin_avg(int sum, int nsq);
    return (sum + nsq / 2) / nsq;
  endfunction

  // Work out the result, if any, that one accepted pixel word causes.
  function automatic void predict_bin(logic fs, logic [16:0] m, logic [7:0] g, logic [7:0] b);
    int nb, lw, nxin, nyin, nxout, nyout, xs, ys, ox, cx, oy, ry, idx, prev, nsq, om, og, ob;
    int v [3];
    int tot [3];
    bin_word_t w;
    nb = shadow_cfg.bin_factor;
    lw = shadow_cfg.line_width;
    if (nb < 1) nb = 1;
    if (nb > 16) nb = 16;
    if (lw < 1) lw = 1;
    if (lw > 4096) lw = 4096;
    if (fs) begin
      cur_col = 0;
      cur_row = 0;
      rows_done = 0;
      err_sent = 0;
    end
    nxin = int'(shadow_cfg.win_x_last) + 1 - int'(shadow_cfg.win_x_first);
    nyin = int'(shadow_cfg.win_y_last) + 1 - int'(shadow_cfg.win_y_first);
    nxout = nxin > 0 ? nxin / nb : 0;
    nyout = nyin > 0 ? nyin / nb : 0;
    xs = int'(shadow_cfg.win_x_first) + (nxin > 0 ? (nxin % nb) / 2 : 0);
    ys = int'(shadow_cfg.win_y_first) + (nyin > 0 ? (nyin % nb) / 2 : 0);
    case (shadow_cfg.pixel_mode)
      wcb_pkg::MODE_SHORT:  v[0] = int'($signed(m[15:0]));
      wcb_pkg::MODE_USHORT: v[0] = int'(m[15:0]);
      default:              v[0] = int'(m[7:0]);
    endcase
    v[1] = shadow_cfg.pixel_mode == wcb_pkg::MODE_RGB ? int'(g) : 0;
    v[2] = shadow_cfg.pixel_mode == wcb_pkg::MODE_RGB ? int'(b) : 0;

    if (nxin > lw) begin
      if (!err_sent) begin
        err_sent = 1;
        w = '{wcb_pkg::STATUS_ERROR, 17'd0, 8'd0, 8'd0, 1'b0, 1'b0};
        pending_bins.push_back(w);
      end
    end else if (!rows_done && nxout > 0 && nyout > 0 && cur_col >= xs &&
                 cur_col - xs < nxout * nb && cur_row >= ys && cur_row - ys < nyout * nb) begin
      ox = (cur_col - xs) / nb;
      cx = (cur_col - xs) % nb;
      oy = (cur_row - ys) / nb;
      ry = (cur_row - ys) % nb;
      for (int ch = 0; ch < 3; ch++)
        run_sums[ch] = cx == 0 ? v[ch] : wrap25(run_sums[ch] + v[ch]);
      if (cx == nb - 1) begin
        for (int ch = 0; ch < 3; ch++) begin
          idx = ox * 3 + ch;
          prev = (nb > 1 && idx < STORE_DEPTH && ry != 0) ? col_sums[idx] : 0;
          tot[ch] = wrap25(prev + run_sums[ch]);
          if (nb > 1 && idx < STORE_DEPTH) col_sums[idx] = tot[ch];
        end
        if (ry == nb - 1) begin
          nsq = nb * nb;
          og = 0;
          ob = 0;
          if (shadow_cfg.pixel_mode == wcb_pkg::MODE_SHORT ||
              shadow_cfg.pixel_mode == wcb_pkg::MODE_USHORT) begin
            om = bin_avg(tot[0], nsq);
          end else if (shadow_cfg.keep_byte) begin
            om = bin_avg(tot[0], nsq);
            if (shadow_cfg.pixel_mode == wcb_pkg::MODE_RGB) begin
              og = bin_avg(tot[1], nsq);
              ob = bin_avg(tot[2], nsq);
            end
          end else if (shadow_cfg.pixel_mode == wcb_pkg::MODE_RGB) begin
            om = sat16(tot[0] + tot[1] + tot[2]);
          end else begin
            om = sat16(tot[0]);
          end
          w.status = wcb_pkg::STATUS_PIXEL;
          w.main = om[16:0];
          w.green = og[7:0];
          w.blue = ob[7:0];
          w.row_end = ox == nxout - 1;
          w.frame_end = ox == nxout - 1 && oy == nyout - 1;
          pending_bins.push_back(w);
        end
      end
    end

    if (cur_col + 1 >= lw) begin
      cur_col = 0;
      if (cur_row >= 4095) rows_done = 1;
      else cur_row++;
    end else begin
      cur_col++;
    end
  endfunction

  // Send one pixel word; the sender works in bursts with random gaps between them.
  task automatic send_pixel(logic fs, logic [16:0] m, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    pix.valid <= 1'b1;
    pix.frame_start <= fs;
    pix.sample_main <= m;
    pix.sample_green <= g;
    pix.sample_blue <= b;
    do @(posedge clk_i); while (!pix.ready);
    predict_bin(fs, m, g, b);
    sent_pixels++;
  endtask

  // Write one register over the configuration channel; the caller drops valid afterwards.
  task automatic write_reg(logic [2:0] idx, logic [12:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      wcb_pkg::REG_PIXEL_MODE:  shadow_cfg.pixel_mode = data[1:0];
      wcb_pkg::REG_BIN_FACTOR:  shadow_cfg.bin_factor = data[4:0];
      wcb_pkg::REG_KEEP_BYTE:   shadow_cfg.keep_byte = data[0];
      wcb_pkg::REG_LINE_WIDTH:  shadow_cfg.line_width = data[12:0];
      wcb_pkg::REG_WIN_X_FIRST: shadow_cfg.win_x_first = data[11:0];
      wcb_pkg::REG_WIN_X_LAST:  shadow_cfg.win_x_last = data[11:0];
      wcb_pkg::REG_WIN_Y_FIRST: shadow_cfg.win_y_first = data[11:0];
      default:                  shadow_cfg.win_y_last = data[11:0];
    endcase
  endtask

  // Stop sending, wait for every pending result, then let the block settle.
  task automatic drain();
    pix.valid <= 1'b0;
    burst_left = 0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(logic [1:0] mode, logic [4:0] nb, logic keep, logic [12:0] lw,
                            logic [11:0] x0, logic [11:0] x1, logic [11:0] y0, logic [11:0] y1);
    drain();
    write_reg(wcb_pkg::REG_PIXEL_MODE, 13'(mode));
    write_reg(wcb_pkg::REG_BIN_FACTOR, 13'(nb));
    write_reg(wcb_pkg::REG_KEEP_BYTE, 13'(keep));
    write_reg(wcb_pkg::REG_LINE_WIDTH, lw);
    write_reg(wcb_pkg::REG_WIN_X_FIRST, 13'(x0));
    write_reg(wcb_pkg::REG_WIN_X_LAST, 13'(x1));
    write_reg(wcb_pkg::REG_WIN_Y_FIRST, 13'(y0));
    write_reg(wcb_pkg::REG_WIN_Y_LAST, 13'(y1));
    cfg.valid <= 1'b0;
  endtask

  function automatic logic [16:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 17'h1FFFF;
      1: return 17'h00000;
      2: return 17'h08000;
      3: return 17'h07FFF;
      default: return 17'($urandom);
    endcase
  endfunction

  // Raster frame of random pixels; restart_at >= 0 puts a stray frame start there.
  task automatic send_frame(int lw, int rows, int restart_at);
    for (int n = 0; n < lw * rows; n++)
      send_pixel(n == 0 || n == restart_at, rand_sample(), 8'($urandom), 8'($urandom));
  endtask

  // Frame of one constant pixel value.
  task automatic send_flat(int count, logic [16:0] m, logic [7:0] g, logic [7:0] b);
    for (int n = 0; n < count; n++) send_pixel(n == 0, m, g, b);
  endtask

  task automatic test_reset_values();
    send_pixel(1'b1, 17'h1FFFF, 8'hFF, 8'hFF);
    send_pixel(1'b0, 17'h00000, 8'h00, 8'h00);
    send_pixel(1'b0, 17'h0FF80, 8'h12, 8'h34);
    send_pixel(1'b0, 17'h10001, 8'h00, 8'h00);
  endtask

  // Every mode with and without keep-byte, with extreme pixel values.
  task automatic test_modes();
    for (int md = 0; md < 4; md++)
      for (int kb = 0; kb < 2; kb++) begin
        set_config(2'(md), 5'd2, 1'(kb), 13'd4, 12'd0, 12'd3, 12'd0, 12'd1);
        send_pixel(1'b1, 17'h1FFFF, 8'hFF, 8'hFF);
        send_pixel(1'b0, 17'h08000, 8'h00, 8'hFF);
        send_pixel(1'b0, 17'h00000, 8'h00, 8'h00);
        send_pixel(1'b0, 17'h07FFF, 8'h80, 8'h01);
        send_pixel(1'b0, 17'h10000, 8'hFF, 8'h00);
        send_pixel(1'b0, 17'h18000, 8'h7F, 8'hFF);
        send_pixel(1'b0, 17'h0FFFF, 8'h01, 8'h80);
        send_pixel(1'b0, 17'h000FF, 8'hFE, 8'h00);
      end
  endtask

  // Window wider than the line gives one error per frame start.
  task automatic test_wide_window();
    set_config(wcb_pkg::MODE_BYTE, 5'd1, 1'b1, 13'd4, 12'd0, 12'd9, 12'd0, 12'd3);
    send_frame(4, 2, -1);
    send_frame(4, 1, 2);
  endtask

  // Empty windows: last before first, and smaller than the bin.
  task automatic test_empty_window();
    set_config(wcb_pkg::MODE_SHORT, 5'd1, 1'b1, 13'd4, 12'd3, 12'd1, 12'd0, 12'd3);
    send_frame(4, 4, -1);
    set_config(wcb_pkg::MODE_SHORT, 5'd3, 1'b1, 13'd4, 12'd0, 12'd1, 12'd0, 12'd3);
    send_frame(4, 4, -1);
  endtask

  // Bin factor zero acts as one; a large RGB sum saturates.
  task automatic test_bin_limits();
    set_config(wcb_pkg::MODE_USHORT, 5'd0, 1'b1, 13'd3, 12'd0, 12'd2, 12'd0, 12'd1);
    send_frame(3, 2, -1);
    set_config(wcb_pkg::MODE_RGB, 5'd7, 1'b0, 13'd7, 12'd0, 12'd6, 12'd0, 12'd6);
    send_flat(49, 17'h000FF, 8'hFF, 8'hFF);
  endtask

  // Line width zero acts as one; above the maximum acts as the maximum.
  task automatic test_line_limits();
    set_config(wcb_pkg::MODE_BYTE, 5'd2, 1'b0, 13'd0, 12'd0, 12'd0, 12'd0, 12'd3);
    send_frame(1, 6, -1);
    set_config(wcb_pkg::MODE_BYTE, 5'd1, 1'b0, 13'd8191, 12'd0, 12'd4095, 12'd0, 12'd0);
    send_frame(6, 1, -1);
  endtask

  // Centering by half the remainder, and blocks that run past the line end.
  task automatic test_centering();
    set_config(wcb_pkg::MODE_SHORT, 5'd3, 1'b1, 13'd9, 12'd0, 12'd7, 12'd1, 12'd8);
    send_frame(9, 9, -1);
    set_config(wcb_pkg::MODE_USHORT, 5'd2, 1'b1, 13'd6, 12'd3, 12'd8, 12'd0, 12'd1);
    send_frame(6, 2, -1);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    set_config(wcb_pkg::MODE_BYTE, 5'd1, 1'b1, 13'd8, 12'd0, 12'd7, 12'd0, 12'd7);
    hold_cycles = 3000;
    send_frame(8, 4, -1);
  endtask

  task automatic test_random();
    int nb, lw, x0, x1, y0, y1, rows, restart;
    while (sent_pixels < 400) begin
      nb = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
      lw = $urandom_range(nb, 14);
      x0 = $urandom_range(0, lw - nb);
      x1 = ($urandom_range(0, 7) == 0) ? $urandom_range(x0, x0 + 16) : $urandom_range(x0, lw - 1);
      y0 = $urandom_range(0, 3);
      y1 = $urandom_range(y0, y0 + 2 * nb + 1);
      rows = ($urandom_range(0, 5) == 0) ? $urandom_range(1, y1 + 1) : y1 + 1;
      restart = ($urandom_range(0, 7) == 0) ? $urandom_range(1, lw * rows) : -1;
      set_config(2'($urandom), 5'(nb), 1'($urandom), 13'(lw), 12'(x0), 12'(x1), 12'(y0),
                 12'(y1));
      send_frame(lw, rows, restart);
    end
  endtask

  // Receiver: stall pattern, long hold-off when asked, and the check of each word.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    bin_word_t w;
    if (res.valid && res.ready) begin
      if (pending_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        w = pending_bins.pop_front();
        if (res.status !== w.status || res.result_main !== w.main ||
            res.result_green !== w.green || res.result_blue !== w.blue ||
            res.row_end !== w.row_end || res.frame_end !== w.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: expected st %0b m %h g %h b %h re %0b fe %0b,",
                      " got st %0b m %h g %h b %h re %0b fe %0b"},
                     $realtime, w.status, w.main, w.green, w.blue, w.row_end, w.frame_end,
                     res.status, res.result_main, res.result_green, res.result_blue,
                     res.row_end, res.frame_end);
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    if (hold_cycles > 0) begin
      hold_cycles--;
      res.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= 1'($urandom);
        default: res.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.frame_start = 1'b0;
    pix.sample_main = '0;
    pix.sample_green = '0;
    pix.sample_blue = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = wcb_pkg::REG_PIXEL_MODE;
    cfg.data = '0;
    shadow_cfg = '{wcb_pkg::MODE_BYTE, 5'd1, 1'b1, 13'd4096, 12'd0, 12'd4095, 12'd0,
                   12'd4095};
    foreach (col_sums[i]) col_sums[i] = 0;
    run_sums = '{0, 0, 0};
    cur_col = 0;
    cur_row = 0;
    err_sent = 0;
    rows_done = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_modes();
    test_wide_window();
    test_empty_window();
    test_bin_limits();
    test_line_limits();
    test_centering();
    test_backpressure();
    test_random();
    drain();

    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/wcb_pkg.sv
rtl/core/wcb_intf.sv
rtl/core/wcb_divider.sv
rtl/core/wcb_datapath.sv
rtl/core/wcb_ctrl.sv
rtl/core/window_crop_and_bin_reduce.sv
verif/tb_window_crop_and_bin_reduce.sv
